FILE: design/ctpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctpf_pkg
// Shared types and constants for the color temperature pixel filter: payload
// structs, register indexes, the gain sequencer states and the whitepoint table.
// ----------------------------------------------------------------------------
package ctpf_pkg;

  localparam int KELVIN_W   = 13;
  localparam int GAIN_W     = 17;
  localparam int CH_W       = 8;
  localparam int TABLE_ROWS = 10;
  localparam int ROW_W      = $clog2(TABLE_ROWS);

  localparam logic [KELVIN_W-1:0] KELVIN_MIN = KELVIN_W'(1000);
  localparam logic [KELVIN_W-1:0] KELVIN_MAX = KELVIN_W'(6500);
  localparam logic [GAIN_W-1:0]   GAIN_ONE   = GAIN_W'(65536);

  localparam logic CFG_KELVIN = 1'b0;
  localparam logic CFG_FORMAT = 1'b1;

  localparam logic FMT_ARGB8888 = 1'b0;
  localparam logic FMT_RGB565   = 1'b1;

  localparam logic [KELVIN_W-1:0] TAB_K [TABLE_ROWS] = '{
    13'd1000, 13'd1500, 13'd2000, 13'd2500, 13'd3000,
    13'd3500, 13'd4000, 13'd4500, 13'd5000, 13'd6500
  };

  localparam logic [GAIN_W-1:0] TAB_G [TABLE_ROWS] = '{
    17'd11910, 17'd27737, 17'd35625, 17'd42187, 17'd47171,
    17'd51110, 17'd54300, 17'd56925, 17'd59112, 17'd65536
  };

  localparam logic [GAIN_W-1:0] TAB_B [TABLE_ROWS] = '{
    17'd0,     17'd0,     17'd5689,  17'd18887, 17'd28089,
    17'd35810, 17'd42478, 17'd48293, 17'd53390, 17'd65536
  };

  typedef struct packed {
    logic [31:0] pixel_in;
    logic        end_of_row;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        end_of_row_out;
    logic        warming_active;
  } out_item_t;

  typedef enum logic [1:0] {
    GS_IDLE,
    GS_SETUP,
    GS_MUL,
    GS_SUM_DIV
  } gain_state_t;

endpackage : ctpf_pkg
`default_nettype wire

FILE: design/color_temperature_pixel_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// color_temperature_pixel_filter_core
// Warms ARGB8888 or RGB565 pixels by scaling green and blue with gains
// interpolated from a whitepoint table at the programmed kelvin value.
// ----------------------------------------------------------------------------
// Pixels stream at one per clock while in_stall is low, through a
// three-stage pipeline (unpack, multiply by gain, round/saturate/pack into
// the output register); a pixel transfers out of the output register when
// out_stall is low, and bubbles collapse while the output is stalled. A
// kelvin write starts the gain sequencer: bracket lookup, product, sum and
// a bit-serial restoring divide of 31 steps, during which in_stall is high;
// a further kelvin write restarts it. in_stall is also high in the cycle of
// any configuration write. Program registers only while no pixels are in
// flight.
// ----------------------------------------------------------------------------
module color_temperature_pixel_filter_core
  import ctpf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [KELVIN_W-1:0] cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_item_t                out_data
);

  localparam int DW     = GAIN_W + KELVIN_W + 1;
  localparam int CNT_W  = $clog2(DW);
  localparam int PROD_W = CH_W + GAIN_W;
  localparam int SAT_W  = PROD_W - 15;
  localparam int RND    = 32768;

  // ---------------------------------------------------------------- config
  logic [KELVIN_W-1:0] kelvin_r;
  logic                format_r;
  logic [GAIN_W-1:0]   gain_g_r;
  logic [GAIN_W-1:0]   gain_b_r;
  logic                warm_r;
  logic [KELVIN_W-1:0] kelvin_clamp;

  gain_state_t state_r;
  gain_state_t state_nxt;
  logic        busy;

  always_comb begin
    if (cfg_wdata < KELVIN_MIN) begin
      kelvin_clamp = KELVIN_MIN;
    end else if (cfg_wdata > KELVIN_MAX) begin
      kelvin_clamp = KELVIN_MAX;
    end else begin
      kelvin_clamp = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kelvin_r <= KELVIN_MAX;
      format_r <= FMT_ARGB8888;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KELVIN: kelvin_r <= kelvin_clamp;
        CFG_FORMAT: format_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- gain sequencer
  logic [ROW_W-1:0]    row_idx;
  logic [ROW_W-1:0]    row_hi;
  logic                row_stop;
  logic [KELVIN_W-1:0] span_c;
  logic [KELVIN_W-1:0] t_c;
  logic                interp_ok;

  logic [KELVIN_W-1:0] span_r;
  logic [KELVIN_W-1:0] t_r;
  logic [GAIN_W-1:0]   glo_r, ghi_r, blo_r, bhi_r;
  logic [DW-1:0]       gp0_r, gp1_r, bp0_r, bp1_r;
  logic [DW-1:0]       gnum_r, bnum_r;
  logic [KELVIN_W-1:0] grem_r, brem_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                div_run_r;

  logic [KELVIN_W:0]   grem_sh, brem_sh;
  logic                g_ge, b_ge;
  logic [DW-1:0]       gnum_nxt, bnum_nxt;
  logic [KELVIN_W-1:0] grem_nxt, brem_nxt;

  always_comb begin
    row_idx  = '0;
    row_stop = 1'b0;
    for (int j = 1; j <= TABLE_ROWS - 2; j++) begin
      if (!row_stop && TAB_K[j] < kelvin_r) begin
        row_idx = ROW_W'(j);
      end else begin
        row_stop = 1'b1;
      end
    end
    row_hi    = row_idx + ROW_W'(1);
    interp_ok = (TAB_K[row_hi] > TAB_K[row_idx]) && (kelvin_r >= TAB_K[row_idx]);
    span_c    = TAB_K[row_hi] - TAB_K[row_idx];
    t_c       = kelvin_r - TAB_K[row_idx];
    if (t_c > span_c) begin
      t_c = span_c;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      GS_IDLE: begin
        if (cfg_we && cfg_index == CFG_KELVIN) begin
          state_nxt = GS_SETUP;
        end
      end
      GS_SETUP:   state_nxt = GS_MUL;
      GS_MUL:     state_nxt = GS_SUM_DIV;
      GS_SUM_DIV: begin
        if (div_run_r && cnt_r == '0) begin
          state_nxt = GS_IDLE;
        end
      end
      default:    state_nxt = GS_IDLE;
    endcase
    if (cfg_we && cfg_index == CFG_KELVIN) begin
      state_nxt = GS_SETUP;
    end
  end

  always_comb begin
    unique case (state_r)
      GS_IDLE: busy = 1'b0;
      default: busy = 1'b1;
    endcase
  end

  always_comb begin
    grem_sh  = {grem_r, gnum_r[DW-1]};
    brem_sh  = {brem_r, bnum_r[DW-1]};
    g_ge     = grem_sh >= {1'b0, span_r};
    b_ge     = brem_sh >= {1'b0, span_r};
    grem_nxt = g_ge ? KELVIN_W'(grem_sh - {1'b0, span_r}) : grem_sh[KELVIN_W-1:0];
    brem_nxt = b_ge ? KELVIN_W'(brem_sh - {1'b0, span_r}) : brem_sh[KELVIN_W-1:0];
    gnum_nxt = {gnum_r[DW-2:0], g_ge};
    bnum_nxt = {bnum_r[DW-2:0], b_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= GS_IDLE;
      div_run_r <= 1'b0;
      gain_g_r  <= GAIN_ONE;
      gain_b_r  <= GAIN_ONE;
      warm_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        GS_MUL: div_run_r <= 1'b0;
        GS_SUM_DIV: begin
          div_run_r <= 1'b1;
          if (div_run_r && cnt_r == '0) begin
            gain_g_r <= gnum_nxt[GAIN_W-1:0];
            gain_b_r <= bnum_nxt[GAIN_W-1:0];
            warm_r   <= (gnum_nxt[GAIN_W-1:0] < GAIN_ONE) ||
                        (bnum_nxt[GAIN_W-1:0] < GAIN_ONE);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      GS_SETUP: begin
        glo_r <= TAB_G[row_idx];
        ghi_r <= TAB_G[row_hi];
        blo_r <= TAB_B[row_idx];
        bhi_r <= TAB_B[row_hi];
        // degenerate bracket: divide the low row's gain by one
        span_r <= interp_ok ? span_c : KELVIN_W'(1);
        t_r    <= interp_ok ? t_c : '0;
      end
      GS_MUL: begin
        gp0_r <= DW'(glo_r * (span_r - t_r));
        gp1_r <= DW'(ghi_r * t_r);
        bp0_r <= DW'(blo_r * (span_r - t_r));
        bp1_r <= DW'(bhi_r * t_r);
      end
      GS_SUM_DIV: begin
        if (!div_run_r) begin
          gnum_r <= gp0_r + gp1_r + DW'(span_r >> 1);
          bnum_r <= bp0_r + bp1_r + DW'(span_r >> 1);
          grem_r <= '0;
          brem_r <= '0;
          cnt_r  <= CNT_W'(DW - 1);
        end else begin
          gnum_r <= gnum_nxt;
          bnum_r <= bnum_nxt;
          grem_r <= grem_nxt;
          brem_r <= brem_nxt;
          cnt_r  <= cnt_r - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------- pixel pipeline
  logic s1_v_r, s2_v_r, out_v_r;
  logic adv1, adv2, adv3;

  logic [CH_W-1:0] s1_a_r, s1_r_r, s1_g_r, s1_b_r;
  logic            s1_fmt_r, s1_eor_r;
  logic [CH_W-1:0] a_nxt, r_nxt, g_nxt, b_nxt;

  logic [CH_W-1:0]   s2_a_r, s2_r_r;
  logic [PROD_W-1:0] s2_gp_r, s2_bp_r;
  logic              s2_fmt_r, s2_eor_r;

  logic [PROD_W:0]   g_rnd, b_rnd;
  logic [SAT_W-1:0]  g_sh, b_sh;
  logic [CH_W-1:0]   g_max, b_max, g_sat, b_sat;
  out_item_t         out_nxt;
  out_item_t         out_r;

  assign adv3     = !out_v_r || !out_stall;
  assign adv2     = !s2_v_r || adv3;
  assign adv1     = !s1_v_r || adv2;
  assign in_stall = busy || cfg_we || !adv1;

  always_comb begin
    if (format_r == FMT_RGB565) begin
      a_nxt = '0;
      r_nxt = CH_W'(in_data.pixel_in[15:11]);
      g_nxt = CH_W'(in_data.pixel_in[10:5]);
      b_nxt = CH_W'(in_data.pixel_in[4:0]);
    end else begin
      a_nxt = in_data.pixel_in[31:24];
      r_nxt = in_data.pixel_in[23:16];
      g_nxt = in_data.pixel_in[15:8];
      b_nxt = in_data.pixel_in[7:0];
    end
  end

  always_comb begin
    g_rnd = {1'b0, s2_gp_r} + (PROD_W+1)'(RND);
    b_rnd = {1'b0, s2_bp_r} + (PROD_W+1)'(RND);
    g_sh  = g_rnd[PROD_W:16];
    b_sh  = b_rnd[PROD_W:16];
    g_max = (s2_fmt_r == FMT_RGB565) ? CH_W'(8'h3f) : CH_W'(8'hff);
    b_max = (s2_fmt_r == FMT_RGB565) ? CH_W'(8'h1f) : CH_W'(8'hff);
    g_sat = (g_sh > SAT_W'(g_max)) ? g_max : g_sh[CH_W-1:0];
    b_sat = (b_sh > SAT_W'(b_max)) ? b_max : b_sh[CH_W-1:0];
    if (s2_fmt_r == FMT_RGB565) begin
      out_nxt.pixel_out = {16'h0000, s2_r_r[4:0], g_sat[5:0], b_sat[4:0]};
    end else begin
      out_nxt.pixel_out = {s2_a_r, s2_r_r, g_sat, b_sat};
    end
    out_nxt.end_of_row_out = s2_eor_r;
    out_nxt.warming_active = warm_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_v_r <= in_valid && !in_stall;
      end
      if (adv2) begin
        s2_v_r <= s1_v_r;
      end
      if (adv3) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_a_r   <= a_nxt;
      s1_r_r   <= r_nxt;
      s1_g_r   <= g_nxt;
      s1_b_r   <= b_nxt;
      s1_fmt_r <= format_r;
      s1_eor_r <= in_data.end_of_row;
    end
    if (adv2) begin
      s2_a_r   <= s1_a_r;
      s2_r_r   <= s1_r_r;
      s2_gp_r  <= s1_g_r * gain_g_r;
      s2_bp_r  <= s1_b_r * gain_b_r;
      s2_fmt_r <= s1_fmt_r;
      s2_eor_r <= s1_eor_r;
    end
    if (adv3) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule : color_temperature_pixel_filter_core
`default_nettype wire

FILE: sim/color_temperature_pixel_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_temperature_pixel_filter_core_tb
// Self-checking bench for the pixel warming filter. A short directed table
// covers reset gains, kelvin clamping, format selection and RGB565 upper bits.
// Random pixels then stream under changing kelvin and format settings and
// three sender/receiver idle mixes. Every output transfer is checked, against
// the table's expected item or else an in-bench whitepoint gain model.
// ----------------------------------------------------------------------------
module color_temperature_pixel_filter_core_tb;
  import ctpf_pkg::*;

  localparam int          WP_ROWS     = 10;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int          SHOW_MAX    = 20;
  localparam logic [16:0] GAIN_UNITY  = 17'd65536;

  localparam int unsigned WP_K [WP_ROWS] = '{
    1000, 1500, 2000, 2500, 3000, 3500, 4000, 4500, 5000, 6500
  };
  localparam int unsigned WP_G [WP_ROWS] = '{
    11910, 27737, 35625, 42187, 47171, 51110, 54300, 56925, 59112, 65536
  };
  localparam int unsigned WP_B [WP_ROWS] = '{
    0, 0, 5689, 18887, 28089, 35810, 42478, 48293, 53390, 65536
  };

  typedef enum logic [1:0] {
    ROW_PIXEL,
    ROW_KELVIN,
    ROW_FORMAT
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;
    logic        eor;
    logic        typed;
    out_item_t   want;
  } stim_row_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic                cfg_index  = CFG_KELVIN;
  logic [KELVIN_W-1:0] cfg_wdata  = '0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  in_item_t            in_data    = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  out_item_t           out_data;

  // typed expectation riding along with the current input transfer
  logic                tag_typed  = 1'b0;
  out_item_t           tag_want   = '0;

  int unsigned         send_pct   = 0;
  int unsigned         recv_pct   = 0;
  int unsigned         cycles     = 0;
  int unsigned         pixels_in  = 0;
  int unsigned         pixels_out = 0;
  int unsigned         reg_writes = 0;
  int unsigned         mismatch_count = 0;

  logic                fmt_now    = FMT_ARGB8888;
  logic [16:0]         gain_r     = GAIN_UNITY;
  logic [16:0]         gain_g     = GAIN_UNITY;
  logic [16:0]         gain_b     = GAIN_UNITY;

  out_item_t           pending_pixels [$];
  stim_row_t           dir_rows [$];

  color_temperature_pixel_filter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_pixels.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [16:0] blend_gain(input longint unsigned lo,
                                             input longint unsigned hi,
                                             input longint unsigned t,
                                             input longint unsigned span);
    longint unsigned num;
    num = lo * (span - t) + hi * t;
    return 17'((num + span / 2) / span);
  endfunction

  function automatic void tune_whitepoint(input logic [KELVIN_W-1:0] raw);
    int unsigned k;
    int unsigned i;
    int unsigned span;
    int unsigned t;
    k = raw;
    if (k < 1000) k = 1000;
    if (k > 6500) k = 6500;
    i = 0;
    while (i + 2 < WP_ROWS && WP_K[i + 1] < k) i++;
    gain_r = GAIN_UNITY;
    if (WP_K[i + 1] > WP_K[i] && k >= WP_K[i]) begin
      span = WP_K[i + 1] - WP_K[i];
      t    = k - WP_K[i];
      if (t > span) t = span;
      gain_g = blend_gain(WP_G[i], WP_G[i + 1], t, span);
      gain_b = blend_gain(WP_B[i], WP_B[i + 1], t, span);
    end else begin
      gain_g = 17'(WP_G[i]);
      gain_b = 17'(WP_B[i]);
    end
  endfunction

  function automatic int unsigned apply_gain(input int unsigned v, input logic [16:0] gain,
                                             input int unsigned top);
    longint unsigned wide;
    longint unsigned r;
    wide = v;
    r = (wide * gain + 64'd32768) >> 16;
    return (r > top) ? top : int'(r);
  endfunction

  function automatic out_item_t warm_pixel(input in_item_t x);
    out_item_t   y;
    logic [31:0] p;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    p = x.pixel_in;
    if (fmt_now == FMT_RGB565) begin
      r = apply_gain(p[15:11], gain_r, 31);
      g = apply_gain(p[10:5], gain_g, 63);
      b = apply_gain(p[4:0], gain_b, 31);
      y.pixel_out = {16'h0000, r[4:0], g[5:0], b[4:0]};
    end else begin
      r = apply_gain(p[23:16], gain_r, 255);
      g = apply_gain(p[15:8], gain_g, 255);
      b = apply_gain(p[7:0], gain_b, 255);
      y.pixel_out = {p[31:24], r[7:0], g[7:0], b[7:0]};
    end
    y.end_of_row_out = x.end_of_row;
    y.warming_active = (gain_g < GAIN_UNITY) || (gain_b < GAIN_UNITY);
    return y;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= SHOW_MAX)
      $display("mismatch at result %0d (cycle %0d): %s got 0x%08h want 0x%08h",
               pixels_out, cycles, field, got, want);
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pending_pixels.push_back(tag_typed ? tag_want : warm_pixel(in_data));
        pixels_in++;
      end
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch("unexpected transfer", out_data.pixel_out, '0);
        end else begin
          want = pending_pixels.pop_front();
          if (out_data.pixel_out !== want.pixel_out)
            report_mismatch("pixel_out", out_data.pixel_out, want.pixel_out);
          if (out_data.end_of_row_out !== want.end_of_row_out)
            report_mismatch("end_of_row_out", 32'(out_data.end_of_row_out),
                            32'(want.end_of_row_out));
          if (out_data.warming_active !== want.warming_active)
            report_mismatch("warming_active", 32'(out_data.warming_active),
                            32'(want.warming_active));
        end
        pixels_out++;
      end
    end
  end

  always @(negedge clk) begin
    out_stall = (recv_pct != 0) && ($urandom_range(99) < recv_pct);
  end

  task automatic push_pixel(input logic [31:0] pix, input logic eor, input logic typed,
                            input out_item_t want);
    while ($urandom_range(99) < send_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid            = 1'b1;
    in_data.pixel_in    = pix;
    in_data.end_of_row  = eor;
    tag_typed           = typed;
    tag_want            = want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [KELVIN_W-1:0] val);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    if (idx == CFG_KELVIN) tune_whitepoint(val);
    else fmt_now = val[0];
    reg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
    while (in_stall) @(negedge clk);
  endtask

  task automatic add_row(input row_kind_t kind, input logic [31:0] value, input logic eor,
                         input logic typed, input out_item_t want);
    stim_row_t row;
    row.kind  = kind;
    row.value = value;
    row.eor   = eor;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  function automatic logic [KELVIN_W-1:0] pick_kelvin();
    case ($urandom_range(5))
      0:       return KELVIN_W'($urandom_range(8191));
      1:       return 13'd1000;
      2:       return 13'd6500;
      3:       return KELVIN_W'(WP_K[$urandom_range(WP_ROWS - 1)]);
      default: return KELVIN_W'($urandom_range(6500, 1000));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned send_mix [3];
    int unsigned recv_mix [3];
    stim_row_t   row;
    send_mix = '{23, 66, 0};
    recv_mix = '{66, 23, 0};

    // reset gains are identity
    add_row(ROW_PIXEL,  32'h00000000, 1'b0, 1'b1, out_item_t'({32'h00000000, 1'b0, 1'b0}));
    add_row(ROW_PIXEL,  32'hFFFFFFFF, 1'b1, 1'b1, out_item_t'({32'hFFFFFFFF, 1'b1, 1'b0}));
    add_row(ROW_PIXEL,  32'h12345678, 1'b0, 1'b1, out_item_t'({32'h12345678, 1'b0, 1'b0}));
    // RGB565 drops the upper half word
    add_row(ROW_FORMAT, 32'd1,        1'b0, 1'b0, '0);
    add_row(ROW_PIXEL,  32'hFFFFFFFF, 1'b1, 1'b1, out_item_t'({32'h0000FFFF, 1'b1, 1'b0}));
    add_row(ROW_PIXEL,  32'hABCD0000, 1'b0, 1'b1, out_item_t'({32'h00000000, 1'b0, 1'b0}));
    // kelvin below range clamps to 1000
    add_row(ROW_KELVIN, 32'd0,        1'b0, 1'b0, '0);
    add_row(ROW_PIXEL,  32'h0000FFFF, 1'b0, 1'b1, out_item_t'({32'h0000F960, 1'b0, 1'b1}));
    // format takes bit 0 only
    add_row(ROW_FORMAT, 32'd2,        1'b0, 1'b0, '0);
    add_row(ROW_PIXEL,  32'h80FFFFFF, 1'b1, 1'b1, out_item_t'({32'h80FF2E00, 1'b1, 1'b1}));
    // kelvin above range clamps to 6500
    add_row(ROW_KELVIN, 32'd8191,     1'b0, 1'b0, '0);
    add_row(ROW_PIXEL,  32'hFFFFFFFF, 1'b0, 1'b1, out_item_t'({32'hFFFFFFFF, 1'b0, 1'b0}));
    add_row(ROW_KELVIN, 32'd999,      1'b0, 1'b0, '0);
    add_row(ROW_PIXEL,  32'h7F80FF01, 1'b1, 1'b0, '0);
    add_row(ROW_KELVIN, 32'd6501,     1'b0, 1'b0, '0);
    add_row(ROW_PIXEL,  32'h7F80FF01, 1'b0, 1'b0, '0);
    add_row(ROW_KELVIN, 32'd1500,     1'b0, 1'b0, '0);
    add_row(ROW_PIXEL,  32'hFFFFFFFF, 1'b0, 1'b0, '0);
    add_row(ROW_KELVIN, 32'd2750,     1'b0, 1'b0, '0);
    add_row(ROW_PIXEL,  32'h00808080, 1'b1, 1'b0, '0);
    add_row(ROW_FORMAT, 32'd3,        1'b0, 1'b0, '0);
    add_row(ROW_PIXEL,  32'hFFFFFFFF, 1'b0, 1'b0, '0);
    add_row(ROW_PIXEL,  32'h5555AAAA, 1'b1, 1'b0, '0);
    add_row(ROW_KELVIN, 32'd5001,     1'b0, 1'b0, '0);
    add_row(ROW_PIXEL,  32'h0000F7DE, 1'b0, 1'b0, '0);

    send_pct = send_mix[0];
    recv_pct = recv_mix[0];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      case (row.kind)
        ROW_KELVIN: write_reg(CFG_KELVIN, row.value[KELVIN_W-1:0]);
        ROW_FORMAT: write_reg(CFG_FORMAT, row.value[KELVIN_W-1:0]);
        default:    push_pixel(row.value, row.eor, row.typed, row.want);
      endcase
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_pct = send_mix[ph];
      recv_pct = recv_mix[ph];
      for (int blk = 0; blk < 8; blk++) begin
        write_reg(CFG_FORMAT, KELVIN_W'($urandom_range(8191)));
        write_reg(CFG_KELVIN, pick_kelvin());
        for (int n = 0; n < 73; n++)
          push_pixel($urandom, ($urandom_range(7) == 0), 1'b0, '0);
      end
    end

    in_valid  = 1'b0;
    tag_typed = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("%0d pixel transfers in, %0d out, %0d register writes, %0d cycles",
             pixels_in, pixels_out, reg_writes, cycles);
    $display("both formats, kelvin 1000..6500 with clamping, three idle mixes; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ctpf_pkg.sv
design/color_temperature_pixel_filter_core.sv
sim/color_temperature_pixel_filter_core_tb.sv
